// File: hdl/ksme_pkg.sv
// Package for the k-th smallest penalty mean estimator.
// Holds the sizes, codes, payload types and the controller/datapath interface structs.
// Depends on nothing; every other file of the block but ksme_ram uses it.
`default_nettype none

package ksme_pkg;

	// Sizing of the store and of the penalty values.
	localparam int MAX_K        = 64;
	localparam int PENALTY_BITS = 16;

	// Widths of the transaction fields.
	localparam int PEN_W    = 16;
	localparam int DC_W     = 9;
	localparam int SUM_W    = 48;
	localparam int CNT_W    = 24;
	localparam int MEAN_W   = 24;
	localparam int STATUS_W = 2;

	// Width of a stored penalty: the field, cut to the penalty bits that are used.
	localparam int STORE_W = (PENALTY_BITS < PEN_W) ? PENALTY_BITS : PEN_W;

	// Store addressing and the width of k itself.
	localparam int ADDR_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int K_W    = $clog2(MAX_K + 1);

	// k = max(K_MIN, (disparity_count + K_ROUND) >> K_SHIFT), limited to MAX_K.
	localparam int K_MIN   = 3;
	localparam int K_ROUND = 2;
	localparam int K_SHIFT = 2;

	// Mean in 16.8 fixed point: the dividend is the sum shifted by the fraction bits.
	localparam int FRAC_BITS = 8;
	localparam int DIVD_W    = SUM_W + FRAC_BITS;
	localparam int DIVC_W    = $clog2(DIVD_W + 1);

	// Configuration port.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_DISPARITY_COUNT = 3'd0;
	localparam logic [DC_W-1:0]   DC_RESET             = 9'd16;

	typedef enum logic [0:0] {
		OP_PENALTY = 1'b0,
		OP_FINISH  = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		KIND_PIXEL = 1'b0,
		KIND_FINAL = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_NO_SAMPLES = 2'd1,
		STATUS_ZERO_SUM   = 2'd2
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [PEN_W-1:0] penalty;
	} pen_item_t;

	typedef struct packed {
		kind_t             kind;
		logic [PEN_W-1:0]  kth_value;
		logic [SUM_W-1:0]  running_sum;
		logic [CNT_W-1:0]  pixel_count;
		logic [MEAN_W-1:0] mean_fixed;
		status_t           status;
	} res_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SWEEP,
		ST_ACCUM,
		ST_DIV,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_item;
		logic fill_write;
		logic sweep_start;
		logic sweep_run;
		logic step_position;
		logic accum;
		logic div_start;
		logic div_run;
		logic load_result;
		logic clear_pixel;
		logic clear_totals;
	} ksme_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_finish;
		logic is_fill;
		logic is_last;
		logic sweep_done;
		logic div_done;
		logic mean_ok;
		logic out_free;
	} ksme_status_t;

endpackage

`default_nettype wire

// File: hdl/ksme_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module ksme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/ksme_datapath.sv
// Datapath of the estimator: penalty store, insertion sweep, sums, divider, result register.
// Depends on ksme_pkg and ksme_ram.
`default_nettype none

module ksme_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ksme_pkg::DC_W-1:0]        disparity_count,
	input  ksme_pkg::pen_item_t              pen_item,
	input  ksme_pkg::ksme_cmd_t              cmd,
	output ksme_pkg::ksme_status_t           status,
	output logic                             res_valid,
	input  logic                             res_stall,
	output ksme_pkg::res_item_t              res_item
);

	localparam int DC_W    = ksme_pkg::DC_W;
	localparam int STORE_W = ksme_pkg::STORE_W;
	localparam int ADDR_W  = ksme_pkg::ADDR_W;
	localparam int K_W     = ksme_pkg::K_W;
	localparam int SUM_W   = ksme_pkg::SUM_W;
	localparam int CNT_W   = ksme_pkg::CNT_W;
	localparam int MEAN_W  = ksme_pkg::MEAN_W;
	localparam int DIVD_W  = ksme_pkg::DIVD_W;
	localparam int DIVC_W  = ksme_pkg::DIVC_W;

	// Latched transaction.
	ksme_pkg::op_t        op_q;
	logic [STORE_W-1:0]   pen_q;

	// Pixel and running state.
	logic [DC_W-1:0]          position_q;
	logic [ksme_pkg::MAX_K-1:0] valid_q;
	logic [SUM_W-1:0]         total_q;
	logic [CNT_W-1:0]         pixels_q;

	// Sweep state.
	logic [K_W-1:0]     rd_idx_q;
	logic               pend_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               valid_s1;
	logic               fill_mode_q;
	logic [STORE_W-1:0] carry_q;
	logic [STORE_W-1:0] best_q;

	// Divider state.
	logic [DIVC_W-1:0] div_cnt_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DIVD_W-1:0] quo_q;

	// Result register.
	logic                 out_valid_q;
	ksme_pkg::res_item_t  out_item_q;
	ksme_pkg::res_item_t  res_next;

	// RAM connections.
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [STORE_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [STORE_W-1:0] ram_rdata;

	// Derived configuration.
	logic [DC_W:0]   k_sum;
	logic [DC_W:0]   k_raw;
	logic [DC_W:0]   k_lim;
	logic [K_W-1:0]  k_w;
	logic [DC_W-1:0] count_w;
	logic            is_fill;
	logic            is_last;

	// Sweep arithmetic.
	logic [STORE_W-1:0] old_val;
	logic [STORE_W-1:0] new_val;
	logic [STORE_W-1:0] carry_next;

	// Sum and divider arithmetic.
	logic [SUM_W:0]    sum_ext;
	logic [CNT_W:0]    trial;
	logic              trial_ge;
	logic [MEAN_W-1:0] mean_sat;
	logic              out_free;

	// k and the pixel length follow the register directly.
	assign k_sum = {1'b0, disparity_count} + (DC_W + 1)'(ksme_pkg::K_ROUND);
	assign k_raw = k_sum >> ksme_pkg::K_SHIFT;

	always_comb begin
		if (k_raw < (DC_W + 1)'(ksme_pkg::K_MIN)) begin
			k_lim = (DC_W + 1)'(ksme_pkg::K_MIN);
		end else if (k_raw > (DC_W + 1)'(ksme_pkg::MAX_K)) begin
			k_lim = (DC_W + 1)'(ksme_pkg::MAX_K);
		end else begin
			k_lim = k_raw;
		end
	end

	assign k_w     = K_W'(k_lim);
	assign count_w = (disparity_count == '0) ? DC_W'(1) : disparity_count;
	assign is_fill = (DC_W + 1)'(position_q) < (DC_W + 1)'(k_w);
	assign is_last = ((DC_W + 1)'(position_q) + (DC_W + 1)'(1)) >= (DC_W + 1)'(count_w);

	// Latch the accepted transaction.
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			op_q  <= pen_item.op;
			pen_q <= pen_item.penalty[STORE_W-1:0];
		end
	end

	// Position within the pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (cmd.clear_pixel) begin
			position_q <= '0;
		end else if (cmd.step_position) begin
			position_q <= position_q + DC_W'(1);
		end
	end

	// Valid bits of the store: an entry that is not valid reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_pixel) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// Read side of the sweep: one slot issued per cycle until k slots are done.
	assign ram_re    = cmd.sweep_run && (rd_idx_q < k_w);
	assign ram_raddr = rd_idx_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
		end else if (cmd.sweep_start) begin
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
		end else begin
			pend_s1 <= ram_re;
			if (ram_re) begin
				rd_idx_q <= rd_idx_q + K_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			addr_s1  <= ram_raddr;
			valid_s1 <= valid_q[ram_raddr];
		end
	end

	// Compare-and-swap of the travelling penalty against one slot, or the fill of one slot.
	always_comb begin
		old_val    = valid_s1 ? ram_rdata : '0;
		new_val    = old_val;
		carry_next = carry_q;
		if (fill_mode_q) begin
			if (DC_W'(addr_s1) == position_q) begin
				new_val = pen_q;
			end
		end else if (carry_q < old_val) begin
			new_val    = carry_q;
			carry_next = old_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_start) begin
			carry_q     <= pen_q;
			best_q      <= '0;
			fill_mode_q <= is_fill;
		end else if (pend_s1) begin
			carry_q <= carry_next;
			if (new_val > best_q) begin
				best_q <= new_val;
			end
		end
	end

	// Write port: a direct fill, or the write-back of the slot just compared.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = position_q[ADDR_W-1:0];
		ram_wdata = pen_q;
		if (cmd.fill_write) begin
			ram_we = 1'b1;
		end else if (pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = new_val;
		end
	end

	ksme_ram #(
		.WIDTH (STORE_W),
		.DEPTH (ksme_pkg::MAX_K)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Running sum and pixel count, both saturating.
	assign sum_ext = {1'b0, total_q} + (SUM_W + 1)'(best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			pixels_q <= '0;
		end else if (cmd.clear_totals) begin
			total_q  <= '0;
			pixels_q <= '0;
		end else if (cmd.accum) begin
			total_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
			if (pixels_q != '1) begin
				pixels_q <= pixels_q + CNT_W'(1);
			end
		end
	end

	// Restoring divider: one quotient bit per cycle of (sum << 8) / pixel count.
	assign trial    = {rem_q, quo_q[DIVD_W-1]};
	assign trial_ge = trial >= {1'b0, pixels_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= DIVC_W'(DIVD_W);
		end else if (cmd.div_run && (div_cnt_q != '0)) begin
			div_cnt_q <= div_cnt_q - DIVC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= {total_q, {ksme_pkg::FRAC_BITS{1'b0}}};
		end else if (cmd.div_run && (div_cnt_q != '0)) begin
			if (trial_ge) begin
				rem_q <= CNT_W'(trial - {1'b0, pixels_q});
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
			quo_q <= {quo_q[DIVD_W-2:0], trial_ge};
		end
	end

	assign mean_sat = (quo_q[DIVD_W-1:MEAN_W] != '0) ? '1 : quo_q[MEAN_W-1:0];

	// Result transaction built from the current state.
	always_comb begin
		res_next             = '0;
		res_next.running_sum = total_q;
		res_next.pixel_count = pixels_q;
		if (op_q == ksme_pkg::OP_FINISH) begin
			res_next.kind = ksme_pkg::KIND_FINAL;
			if (pixels_q == '0) begin
				res_next.status = ksme_pkg::STATUS_NO_SAMPLES;
			end else if (total_q == '0) begin
				res_next.status = ksme_pkg::STATUS_ZERO_SUM;
			end else begin
				res_next.status     = ksme_pkg::STATUS_OK;
				res_next.mean_fixed = mean_sat;
			end
		end else begin
			res_next.kind      = ksme_pkg::KIND_PIXEL;
			res_next.kth_value = ksme_pkg::PEN_W'(best_q);
			res_next.status    = ksme_pkg::STATUS_OK;
		end
	end

	// Output register: holds a finished result while new work goes on.
	assign out_free = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_item_q <= res_next;
		end
	end

	assign res_valid = out_valid_q;
	assign res_item  = out_item_q;

	// Status to the controller.
	always_comb begin
		status            = '0;
		status.is_finish  = (op_q == ksme_pkg::OP_FINISH);
		status.is_fill    = is_fill;
		status.is_last    = is_last;
		status.sweep_done = (rd_idx_q >= k_w) && !pend_s1;
		status.div_done   = (div_cnt_q == '0);
		status.mean_ok    = (pixels_q != '0) && (total_q != '0);
		status.out_free   = out_free;
	end

	// The sweep never runs past k slots.
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_run |-> (rd_idx_q <= k_w))
		else $error("sweep index beyond k");

	// A new result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> (!out_valid_q || !res_stall))
		else $error("result register overwritten");

	// Clearing a pixel empties the store and rewinds the position.
	a_pixel_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_pixel |=> ((position_q == '0) && (valid_q == '0)))
		else $error("pixel clear incomplete");

	// The divider counter stays within its step count.
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_cnt_q <= DIVC_W'(DIVD_W))
		else $error("divider counter out of range");

endmodule

`default_nettype wire

// File: hdl/ksme_ctrl.sv
// Controller state machine of the estimator: sequences accept, sweep, sum, divide and result.
// Depends on ksme_pkg.
`default_nettype none

module ksme_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pen_valid,
	output logic                   pen_stall,
	input  ksme_pkg::ksme_status_t status,
	output ksme_pkg::ksme_cmd_t    cmd
);

	ksme_pkg::state_t state_q;
	ksme_pkg::state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ksme_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		pen_stall  = 1'b1;
		case (state_q)
			ksme_pkg::ST_IDLE: begin
				pen_stall     = 1'b0;
				cmd.take_item = pen_valid;
				if (pen_valid) begin
					state_next = ksme_pkg::ST_DISPATCH;
				end
			end
			ksme_pkg::ST_DISPATCH: begin
				if (status.is_finish) begin
					if (status.mean_ok) begin
						cmd.div_start = 1'b1;
						state_next    = ksme_pkg::ST_DIV;
					end else begin
						state_next = ksme_pkg::ST_EMIT;
					end
				end else if (status.is_fill && !status.is_last) begin
					cmd.fill_write    = 1'b1;
					cmd.step_position = 1'b1;
					state_next        = ksme_pkg::ST_IDLE;
				end else begin
					cmd.sweep_start = 1'b1;
					state_next      = ksme_pkg::ST_SWEEP;
				end
			end
			ksme_pkg::ST_SWEEP: begin
				cmd.sweep_run = 1'b1;
				if (status.sweep_done) begin
					if (status.is_last) begin
						state_next = ksme_pkg::ST_ACCUM;
					end else begin
						cmd.step_position = 1'b1;
						state_next        = ksme_pkg::ST_IDLE;
					end
				end
			end
			ksme_pkg::ST_ACCUM: begin
				cmd.accum       = 1'b1;
				cmd.clear_pixel = 1'b1;
				state_next      = ksme_pkg::ST_EMIT;
			end
			ksme_pkg::ST_DIV: begin
				cmd.div_run = 1'b1;
				if (status.div_done) begin
					state_next = ksme_pkg::ST_EMIT;
				end
			end
			ksme_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_result = 1'b1;
					if (status.is_finish) begin
						cmd.clear_pixel  = 1'b1;
						cmd.clear_totals = 1'b1;
					end
					state_next = ksme_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = ksme_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/kth_smallest_mean_estimator_top.sv
// Top level of the k-th smallest penalty mean estimator: configuration register and APB port.
// Depends on ksme_pkg, ksme_ctrl and ksme_datapath.
//
// The block takes a stream of penalty transactions, disparity_count of them per pixel, keeps
// the k smallest in a 64-entry store, k = max(3, (disparity_count+2)/4) limited to 64, and
// after each pixel's last penalty returns its k-th smallest value with the running sum and
// pixel count. A finish transaction returns the mean in unsigned 16.8 fixed point and clears
// the block. One transaction is worked on at a time. A penalty that only fills a free slot
// is written directly; any other penalty runs the insertion sweep, which reads and writes
// back one store slot per cycle through the single RAM port pair. The last penalty of a
// pixel adds the sum update and the result. When a mean is computed, a finish runs the
// divider, which yields one quotient bit per cycle over 56 bits; otherwise it goes
// straight to the result. A result waits in an output register, so the next transaction
// is accepted while the previous result is still stalled.
`default_nettype none

module kth_smallest_mean_estimator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pen_valid,
	output logic                              pen_stall,
	input  ksme_pkg::pen_item_t               pen_item,
	output logic                              res_valid,
	input  logic                              res_stall,
	output ksme_pkg::res_item_t               res_item,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ksme_pkg::APB_AW-1:0]       paddr,
	input  logic [ksme_pkg::APB_DW-1:0]       pwdata,
	output logic [ksme_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);

	logic [ksme_pkg::DC_W-1:0] disparity_count_q;
	logic                      cfg_write;
	ksme_pkg::ksme_cmd_t       cmd;
	ksme_pkg::ksme_status_t    status;

	// Register write at the access phase of an APB transaction.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disparity_count_q <= ksme_pkg::DC_RESET;
		end else if (cfg_write && (paddr == ksme_pkg::ADDR_DISPARITY_COUNT)) begin
			disparity_count_q <= pwdata[ksme_pkg::DC_W-1:0];
		end
	end

	// Read-back of the register; other addresses read as zero.
	always_comb begin
		if (paddr == ksme_pkg::ADDR_DISPARITY_COUNT) begin
			prdata = ksme_pkg::APB_DW'(disparity_count_q);
		end else begin
			prdata = '0;
		end
	end

	ksme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pen_valid (pen_valid),
		.pen_stall (pen_stall),
		.status    (status),
		.cmd       (cmd)
	);

	ksme_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.disparity_count (disparity_count_q),
		.pen_item        (pen_item),
		.cmd             (cmd),
		.status          (status),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res_item        (res_item)
	);

endmodule

`default_nettype wire
